@@ rtl/vmc_pkg.sv @@
// Shared types, codes and widths for the valve mode controller.
`timescale 1ns / 1ps
`default_nettype none
package vmc_pkg;

  localparam int DIST_W  = 9;
  localparam int POT_W   = 10;
  localparam int SCALE_W = 16;
  localparam int CFG_W   = (DIST_W > SCALE_W) ? DIST_W : SCALE_W;
  localparam int OP_W    = 3;
  localparam int MODE_W  = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_PASS       = 3'd0;
  localparam logic [OP_W-1:0] OP_BUCKET_BTN = 3'd1;
  localparam logic [OP_W-1:0] OP_TIMER_BTN  = 3'd2;
  localparam logic [OP_W-1:0] OP_STATIC_BTN = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET_BTN  = 3'd4;
  localparam logic [OP_W-1:0] OP_OVERFLOW   = 3'd5;

  // mode codes; MODE_NONE only lives in the running-mode register
  localparam logic [MODE_W-1:0] MODE_HAND   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BUCKET = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TIMER  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STATIC = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESET  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NONE   = 3'd5;

  // configuration register indexes
  localparam logic REG_NEAR_THRESHOLD = 1'b0;
  localparam logic REG_TIMER_SCALE    = 1'b1;

  localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RST = DIST_W'(20);
  localparam logic [SCALE_W-1:0] TIMER_SCALE_RST    = SCALE_W'(27490); // 0.41946 in Q0.16

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DIST_W-1:0] distance_cm;
    logic [POT_W-1:0]  pot_value;
  } item_t;

  typedef struct packed {
    logic              valve_open;
    logic [MODE_W-1:0] active_mode;
    logic              bucket_full;
    logic              timer_expired;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/vmc_in_reg.sv @@
// Input register stage: holds one item until the core can take it.
`timescale 1ns / 1ps
`default_nettype none
module vmc_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  vmc_pkg::item_t in_item,
  input  logic          advance,
  output logic          held_valid,
  output vmc_pkg::item_t held_item
);
  import vmc_pkg::*;

  logic  full;
  item_t item;

  assign in_stall   = full && !advance;
  assign held_valid = full;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vmc_core.sv @@
// Mode state, configuration registers and the per-item update logic.
`timescale 1ns / 1ps
`default_nettype none
module vmc_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  vmc_pkg::item_t          item,
  input  logic                    cfg_write_en,
  input  logic                    cfg_index,
  input  logic [vmc_pkg::CFG_W-1:0] cfg_data,
  output vmc_pkg::res_t           res_next
);
  import vmc_pkg::*;

  localparam int LW   = DIST_W + 5;     // room for 5*d and 5*past + 4*|rate|
  localparam int PW   = POT_W + SCALE_W;

  logic [DIST_W-1:0]  near_threshold;
  logic [SCALE_W-1:0] timer_scale;

  logic [MODE_W-1:0]      mode_selected, mode_selected_next;
  logic [MODE_W-1:0]      mode_running, mode_running_next;
  logic                   valve_cmd, valve_cmd_next;
  logic                   control_flag, control_flag_next;
  logic                   status_flag, status_flag_next;
  logic                   full_flag, full_flag_next;
  logic [1:0]             rate_learned, rate_learned_next;
  logic [DIST_W-1:0]      first_distance, first_distance_next;
  logic [DIST_W-1:0]      past_distance, past_distance_next;
  logic signed [DIST_W:0] fall_rate, fall_rate_next;
  logic [POT_W-1:0]       tick_target, tick_target_next;
  logic [POT_W-1:0]       tick_counter, tick_counter_next;
  logic                   timer_armed, timer_armed_next;
  logic                   timer_done, timer_done_next;
  logic [POT_W-1:0]       pot_capture, pot_capture_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= NEAR_THRESHOLD_RST;
      timer_scale    <= TIMER_SCALE_RST;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_NEAR_THRESHOLD) begin
        near_threshold <= cfg_data[DIST_W-1:0];
      end else begin
        timer_scale <= cfg_data[SCALE_W-1:0];
      end
    end
  end

  always_comb begin
    logic                   chk;
    logic                   up;
    logic signed [LW-1:0]   lhs;
    logic signed [LW-1:0]   rhs;
    logic [PW-1:0]          prod;

    mode_selected_next  = mode_selected;
    mode_running_next   = mode_running;
    valve_cmd_next      = valve_cmd;
    control_flag_next   = control_flag;
    status_flag_next    = status_flag;
    full_flag_next      = full_flag;
    rate_learned_next   = rate_learned;
    first_distance_next = first_distance;
    past_distance_next  = past_distance;
    fall_rate_next      = fall_rate;
    tick_target_next    = tick_target;
    tick_counter_next   = tick_counter;
    timer_armed_next    = timer_armed;
    timer_done_next     = timer_done;
    pot_capture_next    = pot_capture;
    chk  = 1'b0;
    up   = 1'b0;
    lhs  = '0;
    rhs  = '0;
    prod = '0;

    case (item.operation)
      OP_PASS: begin
        // mode entry when the selection changed since the last pass
        if (mode_running != mode_selected) begin
          if (mode_selected <= MODE_STATIC) begin
            status_flag_next  = 1'b1;
            control_flag_next = 1'b0;
            valve_cmd_next    = 1'b0;
            if (mode_selected == MODE_BUCKET) begin
              status_flag_next    = 1'b0;
              full_flag_next      = 1'b0;
              rate_learned_next   = 2'd0;
              first_distance_next = '0;
              past_distance_next  = '0;
              fall_rate_next      = '0;
            end else if (mode_selected == MODE_TIMER) begin
              pot_capture_next  = item.pot_value;
              timer_armed_next  = 1'b0;
              timer_done_next   = 1'b0;
              tick_counter_next = '0;
              tick_target_next  = '0;
            end
          end
          mode_running_next = mode_selected;
        end

        case (mode_selected)
          MODE_HAND: begin
            if ((item.distance_cm <= near_threshold) != control_flag_next) begin
              control_flag_next = !control_flag_next;
              valve_cmd_next    = !valve_cmd_next;
            end
          end
          MODE_BUCKET: begin
            if (!full_flag_next) begin
              if (control_flag_next) begin
                if (rate_learned_next == 2'd0) begin
                  first_distance_next = item.distance_cm;
                  rate_learned_next   = 2'd1;
                end else if (rate_learned_next == 2'd1) begin
                  fall_rate_next = $signed({1'b0, first_distance_next})
                                 - $signed({1'b0, item.distance_cm});
                  past_distance_next = item.distance_cm;
                  rate_learned_next  = 2'd2;
                  if (fall_rate_next == '0) begin
                    full_flag_next = 1'b1;
                    chk            = 1'b1;
                  end
                end else begin
                  // full when 5*d > 5*past - 4*rate
                  lhs = $signed(LW'({item.distance_cm, 2'b00}) + LW'(item.distance_cm));
                  rhs = $signed(LW'({past_distance_next, 2'b00}) + LW'(past_distance_next))
                      - $signed({{2{fall_rate_next[DIST_W]}}, fall_rate_next, 2'b00});
                  past_distance_next = item.distance_cm;
                  if (lhs > rhs) begin
                    full_flag_next = 1'b1;
                    chk            = 1'b1;
                  end
                end
              end
              if (chk == control_flag_next) begin
                control_flag_next = !control_flag_next;
                valve_cmd_next    = !valve_cmd_next;
              end
            end else begin
              mode_selected_next = MODE_HAND;
            end
          end
          MODE_TIMER: begin
            if (!timer_armed_next) begin
              prod              = PW'(pot_capture_next) * PW'(timer_scale);
              tick_target_next  = prod[PW-1:SCALE_W];
              tick_counter_next = '0;
              timer_armed_next  = 1'b1;
              status_flag_next  = 1'b1;
            end
            if (status_flag_next) begin
              up = control_flag_next && timer_done_next;
              if (up) begin
                status_flag_next = 1'b0;
              end
              if (up == control_flag_next) begin
                control_flag_next = !control_flag_next;
                valve_cmd_next    = !valve_cmd_next;
              end
            end else begin
              timer_armed_next   = 1'b0;
              timer_done_next    = 1'b0;
              tick_target_next   = '0;
              tick_counter_next  = '0;
              mode_selected_next = MODE_HAND;
            end
          end
          MODE_STATIC: begin
            if (!control_flag_next) begin
              control_flag_next = 1'b1;
              valve_cmd_next    = !valve_cmd_next;
            end
          end
          default: begin
            // reset pending
            valve_cmd_next     = 1'b0;
            mode_running_next  = MODE_NONE;
            mode_selected_next = MODE_HAND;
          end
        endcase
      end
      OP_BUCKET_BTN: begin
        mode_selected_next = (mode_selected == MODE_BUCKET) ? MODE_HAND : MODE_BUCKET;
      end
      OP_TIMER_BTN: begin
        if (mode_selected == MODE_TIMER) begin
          mode_selected_next = MODE_HAND;
        end else begin
          mode_selected_next = MODE_TIMER;
          pot_capture_next   = item.pot_value;
        end
      end
      OP_STATIC_BTN: begin
        mode_selected_next = (mode_selected == MODE_STATIC) ? MODE_HAND : MODE_STATIC;
      end
      OP_RESET_BTN: begin
        mode_selected_next = MODE_RESET;
      end
      OP_OVERFLOW: begin
        if (timer_armed && !timer_done) begin
          tick_counter_next = tick_counter + 1'b1;
          if (tick_counter_next == tick_target) begin
            timer_done_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_selected  <= MODE_HAND;
      mode_running   <= MODE_NONE;
      valve_cmd      <= 1'b0;
      control_flag   <= 1'b0;
      status_flag    <= 1'b0;
      full_flag      <= 1'b0;
      rate_learned   <= 2'd0;
      first_distance <= '0;
      past_distance  <= '0;
      fall_rate      <= '0;
      tick_target    <= '0;
      tick_counter   <= '0;
      timer_armed    <= 1'b0;
      timer_done     <= 1'b0;
      pot_capture    <= '0;
    end else if (advance) begin
      mode_selected  <= mode_selected_next;
      mode_running   <= mode_running_next;
      valve_cmd      <= valve_cmd_next;
      control_flag   <= control_flag_next;
      status_flag    <= status_flag_next;
      full_flag      <= full_flag_next;
      rate_learned   <= rate_learned_next;
      first_distance <= first_distance_next;
      past_distance  <= past_distance_next;
      fall_rate      <= fall_rate_next;
      tick_target    <= tick_target_next;
      tick_counter   <= tick_counter_next;
      timer_armed    <= timer_armed_next;
      timer_done     <= timer_done_next;
      pot_capture    <= pot_capture_next;
    end
  end

  assign res_next.valve_open    = valve_cmd_next;
  assign res_next.active_mode   = mode_selected_next;
  assign res_next.bucket_full   = full_flag_next;
  assign res_next.timer_expired = timer_done_next;

endmodule
`default_nettype wire

@@ rtl/valve_mode_controller.sv @@
// Top level of the valve mode controller: input register, core and result register.
`timescale 1ns / 1ps
`default_nettype none
// Valve mode controller. Each item is an event (pass, mode button, reset button or
// timer overflow); every item yields exactly one result showing valve, selected mode,
// bucket-full and timer-expired status after that event. Items are taken into an
// input register and processed by the core into the result register, so the block
// sustains one item per cycle while out_stall is low; a stalled result holds back
// at most the one item waiting in the input register. The user writes configuration
// (index 0 near threshold, index 1 timer scale) only while idle; it is unenforced.
module valve_mode_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [vmc_pkg::OP_W-1:0]          operation,
  input  logic [vmc_pkg::DIST_W-1:0]        distance_cm,
  input  logic [vmc_pkg::POT_W-1:0]         pot_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              valve_open,
  output logic [vmc_pkg::MODE_W-1:0]        active_mode,
  output logic                              bucket_full,
  output logic                              timer_expired,
  input  logic                              cfg_write_en,
  input  logic                              cfg_index,
  input  logic [vmc_pkg::CFG_W-1:0]         cfg_data
);
  import vmc_pkg::*;

  item_t in_item;
  item_t held_item;
  logic  held_valid;
  logic  advance;
  res_t  res_next;
  res_t  res;
  logic  res_valid;

  assign in_item.operation   = operation;
  assign in_item.distance_cm = distance_cm;
  assign in_item.pot_value   = pot_value;

  // the held item moves on when the result register is empty or draining
  assign advance = held_valid && (!res_valid || !out_stall);

  vmc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  vmc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (held_item),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .res_next     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign out_valid     = res_valid;
  assign valve_open    = res.valve_open;
  assign active_mode   = res.active_mode;
  assign bucket_full   = res.bucket_full;
  assign timer_expired = res.timer_expired;

endmodule
`default_nettype wire

@@ rtl/vmc_checker.sv @@
// Port-level checks for the valve mode controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vmc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       valve_open,
  input logic [vmc_pkg::MODE_W-1:0] active_mode,
  input logic                       bucket_full,
  input logic                       timer_expired
);
  import vmc_pkg::*;

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valve_open) && $stable(active_mode)
      && $stable(bucket_full) && $stable(timer_expired))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // the reported mode never shows the internal no-mode code
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> active_mode <= MODE_RESET)
    else $error("reported mode out of range");

endmodule

bind valve_mode_controller vmc_checker u_vmc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .valve_open    (valve_open),
  .active_mode   (active_mode),
  .bucket_full   (bucket_full),
  .timer_expired (timer_expired)
);
`default_nettype wire

@@ tb/sv/valve_mode_controller_tb.sv @@
// Self-checking testbench for the valve mode controller: event stimulus, status prediction, checks.
`timescale 1ns / 1ps
module valve_mode_controller_tb;
  import vmc_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int RANDOM_ITEMS = 400;
  localparam int SHORT_TICKS  = 16;
  // codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     operation;
  logic [DIST_W-1:0]   distance_cm;
  logic [POT_W-1:0]    pot_value;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                valve_open;
  logic [MODE_W-1:0]   active_mode;
  logic                bucket_full;
  logic                timer_expired;
  logic                cfg_write_en;
  logic                cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  valve_mode_controller u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .distance_cm(distance_cm), .pot_value(pot_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .valve_open(valve_open), .active_mode(active_mode),
    .bucket_full(bucket_full), .timer_expired(timer_expired),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted controller state
  logic [MODE_W-1:0]  sel_mode, run_mode;
  logic               valve_q, ctrl_q, status_q, full_q, armed_q, done_q;
  logic [1:0]         learn_q;
  logic [DIST_W-1:0]  first_d, past_d;
  int                 fall_rate_q;
  logic [POT_W-1:0]   tick_target_q, tick_count_q, pot_cap;
  logic [DIST_W-1:0]  near_thr;
  logic [SCALE_W-1:0] scale_q;

  res_t expected_status[$];
  res_t want, got;
  int   error_count = 0;
  int   cycle_count = 0;
  int   useful_items = 0;
  bit   pace_gaps = 1'b0;
  int   burst_left = 0;
  int   stall_style = 0;
  int   stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  // receiver: switches at random between four stall styles
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycle_count[2];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got.valve_open    = valve_open;
      got.active_mode   = active_mode;
      got.bucket_full   = bucket_full;
      got.timer_expired = timer_expired;
      if (expected_status.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("cycle %0d: unexpected result valve=%0b mode=%0d full=%0b expired=%0b",
                   cycle_count, got.valve_open, got.active_mode, got.bucket_full,
                   got.timer_expired);
      end else begin
        want = expected_status.pop_front();
        if (got.valve_open !== want.valve_open || got.active_mode !== want.active_mode ||
            got.bucket_full !== want.bucket_full ||
            got.timer_expired !== want.timer_expired) begin
          error_count++;
          if (error_count <= 10)
            $display("cycle %0d: exp v=%0b m=%0d f=%0b e=%0b, got v=%0b m=%0d f=%0b e=%0b",
                     cycle_count, want.valve_open, want.active_mode, want.bucket_full,
                     want.timer_expired, got.valve_open, got.active_mode, got.bucket_full,
                     got.timer_expired);
        end
      end
    end
  end

  function automatic void reset_prediction();
    near_thr      = NEAR_THRESHOLD_RST;
    scale_q       = TIMER_SCALE_RST;
    sel_mode      = MODE_HAND;
    run_mode      = MODE_NONE;
    valve_q       = 1'b0;
    ctrl_q        = 1'b0;
    status_q      = 1'b0;
    full_q        = 1'b0;
    learn_q       = 2'd0;
    first_d       = '0;
    past_d        = '0;
    fall_rate_q   = 0;
    tick_target_q = '0;
    tick_count_q  = '0;
    armed_q       = 1'b0;
    done_q        = 1'b0;
    pot_cap       = '0;
  endfunction

  function automatic void toggle_mode(input logic [MODE_W-1:0] m, input logic [POT_W-1:0] pot);
    if (sel_mode == m) begin
      sel_mode = MODE_HAND;
    end else begin
      sel_mode = m;
      if (m == MODE_TIMER) pot_cap = pot;
    end
  endfunction

  function automatic void enter_mode(input logic [MODE_W-1:0] m, input logic [POT_W-1:0] pot);
    if (m <= MODE_STATIC) begin
      status_q = 1'b1;
      ctrl_q   = 1'b0;
      valve_q  = 1'b0;
      if (m == MODE_BUCKET) begin
        status_q    = 1'b0;
        full_q      = 1'b0;
        learn_q     = 2'd0;
        first_d     = '0;
        past_d      = '0;
        fall_rate_q = 0;
      end else if (m == MODE_TIMER) begin
        pot_cap       = pot;
        armed_q       = 1'b0;
        done_q        = 1'b0;
        tick_count_q  = '0;
        tick_target_q = '0;
      end
    end
  endfunction

  function automatic void flip_valve();
    ctrl_q  = !ctrl_q;
    valve_q = !valve_q;
  endfunction

  // one bucket sample; returns 1 when the bucket is judged full
  function automatic logic bucket_sample(input logic [DIST_W-1:0] d);
    longint lhs, rhs;
    if (!ctrl_q) return 1'b0;
    if (learn_q == 2'd0) begin
      first_d = d;
      learn_q = 2'd1;
      return 1'b0;
    end
    if (learn_q == 2'd1) begin
      fall_rate_q = int'(first_d) - int'(d);
      past_d      = d;
      learn_q     = 2'd2;
      if (fall_rate_q == 0) begin
        full_q = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    // full once the level no longer drops by 4/5 of the learned rate
    lhs    = 5 * longint'(d);
    rhs    = 5 * longint'(past_d) - 4 * longint'(fall_rate_q);
    past_d = d;
    if (lhs > rhs) begin
      full_q = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void run_pass(input logic [DIST_W-1:0] d, input logic [POT_W-1:0] pot);
    logic [MODE_W-1:0] m;
    logic up;
    m = sel_mode;
    if (run_mode != m) begin
      enter_mode(m, pot);
      run_mode = m;
    end
    case (m)
      MODE_HAND: begin
        if ((d <= near_thr) != ctrl_q) flip_valve();
      end
      MODE_BUCKET: begin
        if (!full_q) begin
          if (bucket_sample(d) == ctrl_q) flip_valve();
        end else begin
          sel_mode = MODE_HAND;
        end
      end
      MODE_TIMER: begin
        if (!armed_q) begin
          tick_target_q = POT_W'((32'(pot_cap) * 32'(scale_q)) >> SCALE_W);
          tick_count_q  = '0;
          armed_q       = 1'b1;
          status_q      = 1'b1;
        end
        if (status_q) begin
          up = 1'b0;
          if (ctrl_q && done_q) begin
            status_q = 1'b0;
            up       = 1'b1;
          end
          if (up == ctrl_q) flip_valve();
        end else begin
          armed_q       = 1'b0;
          done_q        = 1'b0;
          tick_target_q = '0;
          tick_count_q  = '0;
          sel_mode      = MODE_HAND;
        end
      end
      MODE_STATIC: begin
        if (!ctrl_q) flip_valve();
      end
      default: begin
        // pending reset: close, forget the running mode, back to handwash
        valve_q  = 1'b0;
        run_mode = MODE_NONE;
        sel_mode = MODE_HAND;
      end
    endcase
  endfunction

  function automatic res_t predict_status(input logic [OP_W-1:0] op,
                                          input logic [DIST_W-1:0] d,
                                          input logic [POT_W-1:0] pot);
    res_t r;
    case (op)
      OP_PASS:       run_pass(d, pot);
      OP_BUCKET_BTN: toggle_mode(MODE_BUCKET, pot);
      OP_TIMER_BTN:  toggle_mode(MODE_TIMER, pot);
      OP_STATIC_BTN: toggle_mode(MODE_STATIC, pot);
      OP_RESET_BTN:  sel_mode = MODE_RESET;
      OP_OVERFLOW: begin
        if (armed_q && !done_q) begin
          tick_count_q = tick_count_q + 1'b1;
          if (tick_count_q == tick_target_q) done_q = 1'b1;
        end
      end
      default: ;
    endcase
    r.valve_open    = valve_q;
    r.active_mode   = sel_mode;
    r.bucket_full   = full_q;
    r.timer_expired = done_q;
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] clamp_dist(input int v);
    if (v < 0) return '0;
    if (v > (1 << DIST_W) - 1) return '1;
    return DIST_W'(v);
  endfunction

  // sends one item, paced in bursts with random gaps when pace_gaps is set; records its expected status on acceptance
  task automatic send_event(input logic [OP_W-1:0] op, input logic [DIST_W-1:0] d,
                            input logic [POT_W-1:0] pot);
    int gap;
    gap = 0;
    if (pace_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 7);
      end
      burst_left--;
    end
    if (op <= OP_RESET_BTN || (op == OP_OVERFLOW && armed_q && !done_q))
      useful_items++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    distance_cm <= d;
    pot_value   <= pot;
    do @(posedge clk); while (in_stall);
    expected_status.push_back(predict_status(op, d, pot));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_NEAR_THRESHOLD) near_thr = data[DIST_W-1:0];
    else scale_q = data[SCALE_W-1:0];
  endtask

  task automatic test_directed();
    pace_gaps = 1'b0;
    // handwash around the default threshold and at the distance extremes, then the two spare codes
    send_event(OP_PASS, 9'd0, 10'd0);
    send_event(OP_PASS, 9'd20, 10'd1023);
    send_event(OP_PASS, 9'd21, 10'd0);
    send_event(OP_PASS, 9'd511, 10'd0);
    send_event(OP_SPARE_6, 9'd511, 10'd1023);
    send_event(OP_SPARE_7, 9'd0, 10'd1023);
    // bucket with zero fall rate is full at once, then back to handwash
    send_event(OP_BUCKET_BTN, 9'd0, 10'd0);
    send_event(OP_PASS, 9'd100, 10'd0);
    send_event(OP_PASS, 9'd100, 10'd0);
    send_event(OP_PASS, 9'd100, 10'd0);
    send_event(OP_PASS, 9'd300, 10'd0);
    // short timer: target of two ticks
    send_event(OP_TIMER_BTN, 9'd0, 10'd5);
    send_event(OP_PASS, 9'd0, 10'd5);
    send_event(OP_OVERFLOW, 9'd0, 10'd0);
    send_event(OP_OVERFLOW, 9'd0, 10'd0);
    send_event(OP_PASS, 9'd0, 10'd0);
    send_event(OP_PASS, 9'd0, 10'd0);
    // static, then a reset overridden by a button, then a plain reset
    send_event(OP_STATIC_BTN, 9'd0, 10'd0);
    send_event(OP_PASS, 9'd400, 10'd0);
    send_event(OP_RESET_BTN, 9'd0, 10'd0);
    send_event(OP_BUCKET_BTN, 9'd0, 10'd0);
    send_event(OP_RESET_BTN, 9'd0, 10'd0);
    send_event(OP_PASS, 9'd0, 10'd0);
    settle();
  endtask

  task automatic test_zero_target();
    int k;
    // a zero target keeps the valve open through SHORT_TICKS overflow ticks
    write_reg(REG_TIMER_SCALE, CFG_W'(0));
    pace_gaps = 1'b1;
    send_event(OP_TIMER_BTN, 9'd0, 10'd1023);
    send_event(OP_PASS, 9'd0, 10'd1023);
    for (k = 0; k < SHORT_TICKS; k++)
      send_event(OP_OVERFLOW, DIST_W'($urandom), POT_W'($urandom));
    send_event(OP_PASS, 9'd0, 10'd0);
    send_event(OP_PASS, 9'd0, 10'd0);
    settle();
  endtask

  task automatic random_scenario();
    int kind, n, k, level, rate, stop_at;
    logic [POT_W-1:0] pot;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        if (sel_mode != MODE_HAND) begin
          send_event(OP_RESET_BTN, DIST_W'($urandom), POT_W'($urandom));
          send_event(OP_PASS, DIST_W'($urandom), POT_W'($urandom));
        end
        n = $urandom_range(3, 12);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 1) == 0)
            level = int'(near_thr) + $urandom_range(0, 4) - 2;
          else
            level = $urandom_range(0, 511);
          send_event(OP_PASS, clamp_dist(level), POT_W'($urandom));
        end
      end
      2, 3, 4: begin
        if (sel_mode != MODE_BUCKET) send_event(OP_BUCKET_BTN, DIST_W'($urandom), POT_W'($urandom));
        level   = $urandom_range(150, 511);
        rate    = $urandom_range(0, 12);
        stop_at = $urandom_range(2, 15);
        for (k = 0; k < 40 && sel_mode == MODE_BUCKET; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_event(OP_W'($urandom_range(0, 7)), DIST_W'($urandom), POT_W'($urandom));
          end else begin
            if (k < stop_at) level = level - rate - $urandom_range(0, 1);
            else level = level + $urandom_range(0, 3);
            send_event(OP_PASS, clamp_dist(level), POT_W'($urandom));
          end
        end
      end
      5, 6: begin
        pot = ($urandom_range(0, 9) < 7) ? POT_W'($urandom_range(0, 40)) : POT_W'($urandom);
        if (sel_mode != MODE_TIMER) send_event(OP_TIMER_BTN, DIST_W'($urandom), pot);
        send_event(OP_PASS, DIST_W'($urandom), pot);
        for (k = 0; k < 80 && sel_mode == MODE_TIMER; k++) begin
          if (done_q || $urandom_range(0, 4) == 0)
            send_event(OP_PASS, DIST_W'($urandom), POT_W'($urandom));
          else
            send_event(OP_OVERFLOW, DIST_W'($urandom), POT_W'($urandom));
        end
      end
      7: begin
        if (sel_mode != MODE_STATIC) send_event(OP_STATIC_BTN, DIST_W'($urandom), POT_W'($urandom));
        n = $urandom_range(2, 5);
        for (k = 0; k < n; k++) send_event(OP_PASS, DIST_W'($urandom), POT_W'($urandom));
        send_event(OP_STATIC_BTN, DIST_W'($urandom), POT_W'($urandom));
      end
      8: begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          send_event(OP_W'($urandom_range(0, 7)), DIST_W'($urandom), POT_W'($urandom));
      end
      default: begin
        send_event(OP_RESET_BTN, DIST_W'($urandom), POT_W'($urandom));
        if ($urandom_range(0, 1) == 0)
          send_event(OP_W'($urandom_range(1, 3)), DIST_W'($urandom), POT_W'($urandom));
        send_event(OP_PASS, DIST_W'($urandom), POT_W'($urandom));
      end
    endcase
  endtask

  task automatic test_random();
    int phase, goal;
    logic [DIST_W-1:0]  thr;
    logic [SCALE_W-1:0] scl;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin thr = '0; scl = '1; end
        1: begin thr = '1; scl = SCALE_W'(1024); end
        2: begin thr = NEAR_THRESHOLD_RST; scl = TIMER_SCALE_RST; end
        3: begin thr = DIST_W'($urandom); scl = '0; end
        default: begin thr = DIST_W'($urandom); scl = SCALE_W'($urandom); end
      endcase
      write_reg(REG_NEAR_THRESHOLD, CFG_W'(thr));
      write_reg(REG_TIMER_SCALE, CFG_W'(scl));
      pace_gaps = (phase != 2);
      goal = useful_items + RANDOM_ITEMS / 5;
      while (useful_items < goal) random_scenario();
    end
    settle();
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    operation    <= OP_PASS;
    distance_cm  <= '0;
    pot_value    <= '0;
    cfg_write_en <= 1'b0;
    cfg_index    <= REG_NEAR_THRESHOLD;
    cfg_data     <= '0;
    reset_prediction();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_target();
    test_random();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
